@@ rtl/cbo_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte-offset decoder package
// Shared types and constants for the byte-offset decoder.
// ----------------------------------------------------------------------------
package cbo_pkg;

    // Width of the total_values configuration register.
    localparam int TOTAL_W = 25;

    // Start marker 0C 1A 04 D5: the three leading bytes and the final byte.
    localparam logic [23:0] MARKER_HEAD = 24'h0C1A04;
    localparam logic [7:0]  MARKER_TAIL = 8'hD5;

    // Escape codes of the delta encoding.
    localparam logic [7:0]  ESC8  = 8'h80;
    localparam logic [15:0] ESC16 = 16'h8000;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        KIND_VALUE     = 2'd0,
        KIND_NO_MARKER = 2'd1,
        KIND_SHORT     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_W16_LO = 3'd1,
        PH_W16_HI = 3'd2,
        PH_W32_B0 = 3'd3,
        PH_W32_B1 = 3'd4,
        PH_W32_B2 = 3'd5,
        PH_W32_B3 = 3'd6
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] value;
        logic               last;
    } t_result;

    // Up to two results per decoded byte; slot 1 is used only together with slot 0.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

@@ rtl/cbo_in_if.sv @@
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one stream byte and its end flag.
// ----------------------------------------------------------------------------
interface cbo_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/cbo_out_if.sv @@
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one decoded value or error report.
// ----------------------------------------------------------------------------
interface cbo_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, output result_kind, output value, output last, input ready);
    modport sink   (input valid, input result_kind, input value, input last, output ready);
endinterface

@@ rtl/cbo_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the expected number of values.
// ----------------------------------------------------------------------------
interface cbo_cfg_if;
    logic        valid;
    logic        ready;
    logic [24:0] total_values;

    modport source (output valid, output total_values, input ready);
    modport sink   (input valid, input total_values, output ready);
endinterface

@@ rtl/cbo_decode.sv @@
// ----------------------------------------------------------------------------
// Byte-offset decode stage
// Input register, marker search, delta decode and running sum.
// ----------------------------------------------------------------------------
module cbo_decode
    import cbo_pkg::*;
#(
    parameter int CNT_W = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cbo_in_if.sink           i_in,
    input  logic [CNT_W-1:0] i_target,
    input  logic             i_space_ok,
    output t_push            o_push
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic [23:0]      r_recent, n_recent;
    logic             r_marker_seen, n_marker_seen;
    t_phase           r_phase, n_phase;
    logic [23:0]      r_partial, n_partial;
    logic [31:0]      r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done, n_done;

    logic             proc;
    logic             hit;
    logic             got;
    logic             fin;
    logic [31:0]      delta;
    logic [15:0]      word16;
    logic [CNT_W-1:0] count_inc;
    t_result          err_res;

    // The held byte is consumed once the queue has room for two results.
    assign proc       = r_in_valid && i_space_ok;
    assign i_in.ready = !r_in_valid || proc;
    assign word16     = {r_in_byte, r_partial[7:0]};
    assign count_inc  = r_count + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent      <= '0;
            r_marker_seen <= 1'b0;
            r_phase       <= PH_LEAD;
            r_sum         <= '0;
            r_count       <= '0;
            r_done        <= 1'b0;
        end else begin
            r_recent      <= n_recent;
            r_marker_seen <= n_marker_seen;
            r_phase       <= n_phase;
            r_sum         <= n_sum;
            r_count       <= n_count;
            r_done        <= n_done;
        end
    end

    // Every partial byte is written before it is read, so no reset is needed.
    always_ff @(posedge i_clk) begin
        r_partial <= n_partial;
    end

    always_comb begin
        n_recent      = r_recent;
        n_marker_seen = r_marker_seen;
        n_phase       = r_phase;
        n_partial     = r_partial;
        n_sum         = r_sum;
        n_count       = r_count;
        n_done        = r_done;
        hit           = 1'b0;
        got           = 1'b0;
        fin           = 1'b0;
        delta         = '0;
        o_push        = '0;
        err_res       = '0;

        if (proc) begin
            if (!r_marker_seen) begin
                hit           = (r_recent == MARKER_HEAD) && (r_in_byte == MARKER_TAIL);
                n_marker_seen = hit;
                n_recent      = {r_recent[15:0], r_in_byte};
            end else if (!r_done) begin
                unique case (r_phase)
                    PH_W16_LO: begin
                        n_partial[7:0] = r_in_byte;
                        n_phase        = PH_W16_HI;
                    end
                    PH_W16_HI: begin
                        if (word16 == ESC16) begin
                            n_phase = PH_W32_B0;
                        end else begin
                            got     = 1'b1;
                            delta   = {{16{word16[15]}}, word16};
                            n_phase = PH_LEAD;
                        end
                    end
                    PH_W32_B0: begin
                        n_partial[7:0] = r_in_byte;
                        n_phase        = PH_W32_B1;
                    end
                    PH_W32_B1: begin
                        n_partial[15:8] = r_in_byte;
                        n_phase         = PH_W32_B2;
                    end
                    PH_W32_B2: begin
                        n_partial[23:16] = r_in_byte;
                        n_phase          = PH_W32_B3;
                    end
                    PH_W32_B3: begin
                        got     = 1'b1;
                        delta   = {r_in_byte, r_partial};
                        n_phase = PH_LEAD;
                    end
                    default: begin
                        if (r_in_byte != ESC8) begin
                            got   = 1'b1;
                            delta = {{24{r_in_byte[7]}}, r_in_byte};
                        end else begin
                            n_phase = PH_W16_LO;
                        end
                    end
                endcase
            end

            if (got) begin
                n_sum     = r_sum + delta;
                n_count   = count_inc;
                fin       = (count_inc >= i_target);
                n_done    = fin;
                o_push.v0 = 1'b1;
                o_push.r0 = '{kind: KIND_VALUE, value: n_sum, last: fin};
            end

            if (r_in_last) begin
                // A value decoded from the final byte goes out ahead of the error.
                if (!n_marker_seen) begin
                    err_res = '{kind: KIND_NO_MARKER, value: '0, last: 1'b1};
                end else begin
                    err_res = '{kind: KIND_SHORT, value: '0, last: 1'b1};
                end
                if (!n_marker_seen || !n_done) begin
                    if (got) begin
                        o_push.v1 = 1'b1;
                        o_push.r1 = err_res;
                    end else begin
                        o_push.v0 = 1'b1;
                        o_push.r0 = err_res;
                    end
                end
                n_recent      = '0;
                n_marker_seen = 1'b0;
                n_phase       = PH_LEAD;
                n_sum         = '0;
                n_count       = '0;
                n_done        = 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_done_needs_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_marker_seen)
        else $error("image complete without a start marker");

    a_phase_only_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_LEAD) |-> (r_marker_seen && !r_done))
        else $error("delta in progress outside the data section");

    a_second_is_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v1 |-> (o_push.v0 && o_push.r1.kind != KIND_VALUE && o_push.r1.last))
        else $error("second result of a byte is not a trailing error");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_last) |=> (!r_marker_seen && !r_done && r_count == '0
                                 && r_phase == PH_LEAD))
        else $error("stream state not cleared after the final byte");
`endif

endmodule

@@ rtl/cbo_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results per cycle and sends one per transfer.
// ----------------------------------------------------------------------------
module cbo_out_fifo
    import cbo_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_space_ok,
    cbo_out_if.source o_out
);

    t_result                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count, n_count;
    logic                    pop;
    logic [FIFO_CNT_W-1:0]   push_n;
    t_result                 head;

    assign pop        = o_out.valid && o_out.ready;
    assign push_n     = FIFO_CNT_W'(i_push.v0) + FIFO_CNT_W'(i_push.v1);
    assign o_space_ok = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    assign head              = r_mem[r_rd_ptr];
    assign o_out.valid       = (r_count != '0);
    assign o_out.result_kind = head.kind;
    assign o_out.value       = head.value;
    assign o_out.last        = head.last;

    always_comb begin
        n_wr_ptr = r_wr_ptr + push_n[FIFO_PTR_W-1:0];
        n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
        n_count  = r_count + push_n - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[r_wr_ptr + FIFO_PTR_W'(1)] <= i_push.r1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_count == FIFO_CNT_W'(1) && !i_push.v0) |=> !o_out.valid)
        else $error("result queue shows data after its last entry left");
`endif

endmodule

@@ rtl/cbf_byte_offset_decoder.sv @@
// ----------------------------------------------------------------------------
// Byte-offset decoder
// Finds the 0C 1A 04 D5 start marker in a byte stream and rebuilds the
// pixel values from byte-offset deltas.
// i_in_byte takes one stream byte per transfer, with last_byte set on the
// final byte. o_result sends one result per transfer: a decoded value
// (kind 0), a missing marker (kind 1) or a stream that ended short
// (kind 2); last is set on the final value of an image and on every error.
// i_cfg writes the expected value count; it is always ready, and the user must
// write it only while the block is idle; the block itself does not enforce this.
// Zero counts as one, and counts above MAX_VALUES are held to MAX_VALUES.
// A byte is held in an input register, from which its results go into a
// four-entry result queue. One byte is taken every cycle; a byte that
// yields a value and an error puts two results into the queue, and the
// input waits whenever fewer than two queue entries are free. When the
// receiver stalls the queue fills and then the input stalls; nothing is
// dropped. Reset and the end of every stream clear the stream state;
// reset also sets the expected count to one.
// ----------------------------------------------------------------------------
module cbf_byte_offset_decoder
    import cbo_pkg::*;
#(
    parameter longint unsigned MAX_VALUES = 16777216
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbo_in_if.sink    i_in_byte,
    cbo_cfg_if.sink   i_cfg,
    cbo_out_if.source o_result
);

    localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;
    localparam longint unsigned EFF_MAX   = (MAX_VALUES < TOTAL_MAX) ? MAX_VALUES : TOTAL_MAX;
    localparam int              CNT_W     = $clog2(EFF_MAX + 64'd1);
    localparam logic [TOTAL_W-1:0] TGT_MAX = TOTAL_W'(EFF_MAX);

    logic [CNT_W-1:0]   r_target;
    logic [TOTAL_W-1:0] clamped;
    t_push              push;
    logic               space_ok;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        priority if (i_cfg.total_values == '0) begin
            clamped = TOTAL_W'(1);
        end else if (i_cfg.total_values > TGT_MAX) begin
            clamped = TGT_MAX;
        end else begin
            clamped = i_cfg.total_values;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= CNT_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_target <= clamped[CNT_W-1:0];
        end
    end

    cbo_decode #(
        .CNT_W (CNT_W)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_byte),
        .i_target   (r_target),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    cbo_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_out      (o_result)
    );

`ifndef SYNTHESIS
    a_target_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_target != '0)
        else $error("expected value count is zero");

    a_target_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> (TOTAL_W'(r_target) <= TGT_MAX))
        else $error("expected value count above its limit");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.result_kind != KIND_VALUE)
            |-> (o_result.last && o_result.value == '0))
        else $error("error result without last flag or with a value");
`endif

endmodule

@@ bench/tb_cbf_byte_offset_decoder.sv @@
// ----------------------------------------------------------------------------
// Byte-offset decoder testbench
// Drives byte streams into the decoder and compares every result transfer
// against a behavioral model kept inside the bench. Directed streams cover
// the delta encodings, the marker and stream-end cases and the count limits.
// Random streams with random handshake gaps on both sides follow.
// ----------------------------------------------------------------------------
module tb_cbf_byte_offset_decoder;
    import cbo_pkg::*;

    localparam int unsigned MAX_COUNT    = 16777216;
    localparam int unsigned RANDOM_BYTES = 1400;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE       = 8;

    logic i_clk;
    logic i_rst_n;

    cbo_in_if  in_if ();
    cbo_out_if out_if ();
    cbo_cfg_if cfg_if ();

    cbf_byte_offset_decoder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_byte(in_if),
        .i_cfg    (cfg_if),
        .o_result (out_if)
    );

    // Decoder model state.
    logic [24:0]  total_reg = 25'd1;
    logic [23:0]  recent_q;
    logic         marker_q;
    t_phase       phase_q;
    logic [31:0]  partial_q;
    logic [31:0]  sum_q;
    int unsigned  emitted_q;
    logic         done_q;

    t_result      pending_results[$];
    logic [7:0]   stream_q[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  sent_bytes = 0;
    logic         calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stalls at random except during the calm stretch.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready = calm || ($urandom_range(99) >= 38);
        end
    end

    function automatic int unsigned effective_target(logic [24:0] total);
        if (total == 0)
            return 1;
        if (total > MAX_COUNT)
            return MAX_COUNT;
        return 32'(total);
    endfunction

    function automatic void clear_stream_state();
        recent_q  = '0;
        marker_q  = 1'b0;
        phase_q   = PH_LEAD;
        partial_q = '0;
        sum_q     = '0;
        emitted_q = 0;
        done_q    = 1'b0;
    endfunction

    // Advances the decoder model by one byte and queues the results it causes.
    function automatic void decode_step(logic [7:0] d, logic lb);
        logic [31:0] delta;
        logic        got;
        t_result     r;
        delta = '0;
        got   = 1'b0;
        if (!marker_q) begin
            if (recent_q == MARKER_HEAD && d == MARKER_TAIL)
                marker_q = 1'b1;
            recent_q = {recent_q[15:0], d};
        end else if (!done_q) begin
            unique case (phase_q)
                PH_W16_LO: begin
                    partial_q = {24'h0, d};
                    phase_q   = PH_W16_HI;
                end
                PH_W16_HI: begin
                    partial_q[15:8] = d;
                    if (partial_q[15:0] == ESC16) begin
                        phase_q = PH_W32_B0;
                    end else begin
                        delta   = {{16{partial_q[15]}}, partial_q[15:0]};
                        got     = 1'b1;
                        phase_q = PH_LEAD;
                    end
                    partial_q = '0;
                end
                PH_W32_B0: begin
                    partial_q[7:0] = d;
                    phase_q        = PH_W32_B1;
                end
                PH_W32_B1: begin
                    partial_q[15:8] = d;
                    phase_q         = PH_W32_B2;
                end
                PH_W32_B2: begin
                    partial_q[23:16] = d;
                    phase_q          = PH_W32_B3;
                end
                PH_W32_B3: begin
                    delta     = {d, partial_q[23:0]};
                    got       = 1'b1;
                    partial_q = '0;
                    phase_q   = PH_LEAD;
                end
                default: begin
                    if (d != ESC8) begin
                        delta = {{24{d[7]}}, d};
                        got   = 1'b1;
                    end else begin
                        phase_q = PH_W16_LO;
                    end
                end
            endcase
            if (got) begin
                sum_q = sum_q + delta;
                emitted_q++;
                r.kind  = KIND_VALUE;
                r.value = sum_q;
                r.last  = (emitted_q >= effective_target(total_reg));
                if (r.last)
                    done_q = 1'b1;
                pending_results.push_back(r);
            end
        end
        if (lb) begin
            r.value = '0;
            r.last  = 1'b1;
            if (!marker_q) begin
                r.kind = KIND_NO_MARKER;
                pending_results.push_back(r);
            end else if (!done_q) begin
                r.kind = KIND_SHORT;
                pending_results.push_back(r);
            end
            clear_stream_state();
        end
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind=%0d value=%0d last=%0d",
                         $time, out_if.result_kind, out_if.value, out_if.last);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (out_if.result_kind !== exp_r.kind) begin
                    $display("%0t: result_kind expected %0d actual %0d",
                             $time, exp_r.kind, out_if.result_kind);
                    mismatch_count++;
                end
                if (out_if.value !== exp_r.value) begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, exp_r.value, out_if.value);
                    mismatch_count++;
                end
                if (out_if.last !== exp_r.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, exp_r.last, out_if.last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] d, logic lb);
        while (!calm && $urandom_range(99) < 38) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.data_byte = d;
        in_if.last_byte = lb;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        decode_step(d, lb);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_stream();
        int unsigned i;
        for (i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
        stream_q.delete();
    endtask

    // Holds the input until every queued result has arrived and the pipeline
    // has emptied, so the count register may be rewritten.
    task automatic wait_idle();
        in_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_total(logic [24:0] total);
        cfg_if.valid        = 1'b1;
        cfg_if.total_values = total;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        total_reg = total;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic void push_marker();
        stream_q.push_back(MARKER_HEAD[23:16]);
        stream_q.push_back(MARKER_HEAD[15:8]);
        stream_q.push_back(MARKER_HEAD[7:0]);
        stream_q.push_back(MARKER_TAIL);
    endfunction

    function automatic void push_random_delta();
        int unsigned form;
        logic [7:0]  b;
        logic [15:0] h;
        logic [31:0] w;
        form = $urandom_range(99);
        if (form < 60) begin
            b = 8'($urandom_range(255));
            if (b == ESC8)
                b = 8'h7f;
            stream_q.push_back(b);
        end else if (form < 85) begin
            h = 16'($urandom);
            if (h == ESC16)
                h = 16'h7fff;
            stream_q.push_back(ESC8);
            stream_q.push_back(h[7:0]);
            stream_q.push_back(h[15:8]);
        end else begin
            w = $urandom;
            stream_q.push_back(ESC8);
            stream_q.push_back(ESC16[7:0]);
            stream_q.push_back(ESC16[15:8]);
            stream_q.push_back(w[7:0]);
            stream_q.push_back(w[15:8]);
            stream_q.push_back(w[23:16]);
            stream_q.push_back(w[31:24]);
        end
    endfunction

    // Largest positive 8-bit delta, largest 16-bit deltas of both signs, a 32-bit
    // delta, and a trailing byte after the image is complete.
    task automatic test_delta_forms();
        write_total(25'd4);
        push_marker();
        stream_q.push_back(8'h7f);
        stream_q.push_back(ESC8);
        stream_q.push_back(8'hff);
        stream_q.push_back(8'h7f);
        stream_q.push_back(ESC8);
        stream_q.push_back(8'h01);
        stream_q.push_back(8'h80);
        stream_q.push_back(ESC8);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h80);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h80);
        stream_q.push_back(8'hff);
        send_stream();
    endtask

    // A marker split across two streams, a marker on the final byte, a delta
    // cut off by the stream end, and a value and an error on the same byte
    // where the marker pattern shows up again inside the data.
    task automatic test_stream_ends();
        wait_idle();
        write_total(25'd5);
        stream_q.push_back(MARKER_HEAD[23:16]);
        stream_q.push_back(MARKER_HEAD[15:8]);
        stream_q.push_back(MARKER_HEAD[7:0]);
        send_stream();
        stream_q.push_back(MARKER_TAIL);
        send_stream();
        push_marker();
        send_stream();
        push_marker();
        stream_q.push_back(ESC8);
        send_stream();
        push_marker();
        push_marker();
        send_stream();
    endtask

    // A zero count behaves as one; the largest count is held to the limit.
    task automatic test_count_limits();
        wait_idle();
        write_total(25'd0);
        push_marker();
        stream_q.push_back(8'h05);
        stream_q.push_back(8'h06);
        send_stream();
        wait_idle();
        write_total('1);
        push_marker();
        stream_q.push_back(8'h01);
        stream_q.push_back(ESC8);
        send_stream();
    endtask

    task automatic test_random_streams();
        int unsigned start_bytes;
        int unsigned pick;
        int unsigned tgt;
        int          n;
        int          i;
        start_bytes = sent_bytes;
        while (sent_bytes - start_bytes < RANDOM_BYTES) begin
            calm = (sent_bytes - start_bytes >= 500) && (sent_bytes - start_bytes < 800);
            if ($urandom_range(1) == 0) begin
                wait_idle();
                pick = $urandom_range(99);
                if (pick < 10)
                    write_total(25'd0);
                else if (pick < 70)
                    write_total(25'($urandom_range(12, 1)));
                else if (pick < 92)
                    write_total(25'($urandom_range(60, 13)));
                else
                    write_total(25'($urandom_range(33554431, MAX_COUNT - 3)));
            end
            if ($urandom_range(99) < 82) begin
                // Well-formed image with some noise around it.
                if ($urandom_range(3) == 0) begin
                    stream_q.push_back(MARKER_HEAD[23:16]);
                    stream_q.push_back(MARKER_HEAD[15:8]);
                end
                n = $urandom_range(5);
                for (i = 0; i < n; i++)
                    stream_q.push_back(8'($urandom_range(255)));
                push_marker();
                tgt = effective_target(total_reg);
                if (tgt > 48)
                    n = $urandom_range(40, 1);
                else
                    n = int'(tgt) + int'($urandom_range(4)) - 2;
                for (i = 0; i < n; i++)
                    push_random_delta();
                pick = $urandom_range(9);
                if (pick < 3)
                    stream_q.push_back(ESC8);
                if (pick == 1 || pick == 2)
                    stream_q.push_back(8'($urandom_range(255)));
                if (pick == 2) begin
                    stream_q.push_back(ESC8);
                    stream_q.push_back(8'($urandom_range(255)));
                end
                n = $urandom_range(2);
                for (i = 0; i < n; i++)
                    stream_q.push_back(8'($urandom_range(255)));
            end else begin
                if ($urandom_range(3) == 0) begin
                    stream_q.push_back(MARKER_HEAD[23:16]);
                    stream_q.push_back(MARKER_HEAD[15:8]);
                    stream_q.push_back(MARKER_HEAD[7:0]);
                end
                n = $urandom_range(16, 1);
                for (i = 0; i < n; i++)
                    stream_q.push_back(8'($urandom_range(255)));
            end
            send_stream();
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.data_byte     = '0;
        in_if.last_byte     = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.total_values = '0;
        clear_stream_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_delta_forms();
        test_stream_ends();
        test_count_limits();
        test_random_streams();

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cbo_pkg.sv
rtl/cbo_in_if.sv
rtl/cbo_out_if.sv
rtl/cbo_cfg_if.sv
rtl/cbo_decode.sv
rtl/cbo_out_fifo.sv
rtl/cbf_byte_offset_decoder.sv
bench/tb_cbf_byte_offset_decoder.sv
